### design/nnis_pkg.sv
package nnis_pkg;

  // Source store
  localparam int MAX_SOURCE_PIXELS = 4096;
  localparam int ADDR_W            = $clog2(MAX_SOURCE_PIXELS);
  localparam int PIXEL_W           = 32;

  // Field widths
  localparam int LOAD_ADDR_W = 12;
  localparam int COORD_W     = 8;
  localparam int SRC_DIM_W   = 7;
  localparam int DST_DIM_W   = 9;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 2;

  // Scaling arithmetic: product of a coordinate and a source size, the
  // quotient, which is below the source size, and the remainder, which is
  // below the destination size, both for a coordinate inside the destination.
  localparam int NUM_W     = COORD_W + SRC_DIM_W;
  localparam int QUOT_W    = SRC_DIM_W;
  localparam int REM_W     = DST_DIM_W;
  localparam int SRC_ADDR_W = 2 * SRC_DIM_W + 1;

  // Output queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  // Register reset values
  localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_RST  = 7'd1;
  localparam logic [SRC_DIM_W-1:0] SRC_HEIGHT_RST = 7'd1;
  localparam logic [DST_DIM_W-1:0] DST_WIDTH_RST  = 9'd40;
  localparam logic [DST_DIM_W-1:0] DST_HEIGHT_RST = 9'd40;

  // Opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Per-item control carried down the pipeline.
  typedef struct packed {
    logic                   fetch;
    logic                   err;
    logic [LOAD_ADDR_W-1:0] laddr;
    logic [PIXEL_W-1:0]     lval;
  } tag_t;

  // Divider state of both axes.
  typedef struct packed {
    logic [REM_W-1:0]  rx;
    logic [REM_W-1:0]  ry;
    logic [QUOT_W-1:0] qx;
    logic [QUOT_W-1:0] qy;
    logic [NUM_W-1:0]  px;
    logic [NUM_W-1:0]  py;
  } div_t;

  // One queued result.
  typedef struct packed {
    logic               coord_error;
    logic [PIXEL_W-1:0] pixel_out;
  } res_t;

endpackage

### design/nnis_if.sv
interface nnis_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [nnis_pkg::LOAD_ADDR_W-1:0]  load_address;
  logic [nnis_pkg::PIXEL_W-1:0]      load_value;
  logic [nnis_pkg::COORD_W-1:0]      dest_x;
  logic [nnis_pkg::COORD_W-1:0]      dest_y;

  modport source (output valid, output opcode, output load_address, output load_value,
                  output dest_x, output dest_y, input ready);
  modport sink   (input valid, input opcode, input load_address, input load_value,
                  input dest_x, input dest_y, output ready);
endinterface

interface nnis_out_if;
  logic                         valid;
  logic                         ready;
  logic [nnis_pkg::PIXEL_W-1:0] pixel_out;
  logic                         coord_error;

  modport source (output valid, output pixel_out, output coord_error, input ready);
  modport sink   (input valid, input pixel_out, input coord_error, output ready);
endinterface

### design/nearest_neighbor_image_scaler_top.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    opcode, load_address, load_value, dest_x, dest_y
// out_ch    out  valid/ready    pixel_out, coord_error
// cfg_*     in   cfg_we only    cfg_index, cfg_wdata
//
// One item is accepted per cycle while credits remain; a fetch result goes
// through stage 0, the divider, address and store stages into the queue and
// can be taken at the next edge. The credit count against the 16-entry queue
// covers the pipeline depth, so stalls on out_ch never freeze the pipe.
// Reset is synchronous and active low; it restores the size registers.
// The pixel store needs no clearing pass after reset.

module nearest_neighbor_image_scaler_top (
  input  logic                                clk,
  input  logic                                rst_n,
  nnis_in_if.sink                             in_ch,
  nnis_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int DIV_STAGES = nnis_pkg::QUOT_W;
  localparam logic [nnis_pkg::SRC_ADDR_W-1:0] MAX_ADDR =
    nnis_pkg::SRC_ADDR_W'(nnis_pkg::MAX_SOURCE_PIXELS);

  // Size registers.
  logic [nnis_pkg::SRC_DIM_W-1:0] src_width_r;
  logic [nnis_pkg::SRC_DIM_W-1:0] src_height_r;
  logic [nnis_pkg::DST_DIM_W-1:0] dst_width_r;
  logic [nnis_pkg::DST_DIM_W-1:0] dst_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= nnis_pkg::SRC_WIDTH_RST;
      src_height_r <= nnis_pkg::SRC_HEIGHT_RST;
      dst_width_r  <= nnis_pkg::DST_WIDTH_RST;
      dst_height_r <= nnis_pkg::DST_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nnis_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[nnis_pkg::SRC_DIM_W-1:0];
        nnis_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[nnis_pkg::SRC_DIM_W-1:0];
        nnis_pkg::CFG_DST_WIDTH:  dst_width_r  <= cfg_wdata[nnis_pkg::DST_DIM_W-1:0];
        nnis_pkg::CFG_DST_HEIGHT: dst_height_r <= cfg_wdata[nnis_pkg::DST_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Credits: every fetch in flight or queued holds one queue slot, so the
  // queue can never overflow even when the output side stalls.
  logic [nnis_pkg::FIFO_CNT_W-1:0] credit_r, credit_nxt;
  logic in_fire, fetch_in, out_fire;

  assign in_ch.ready = (credit_r < nnis_pkg::FIFO_CNT_W'(nnis_pkg::FIFO_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign fetch_in    = in_fire && (in_ch.opcode == nnis_pkg::OP_FETCH);
  assign out_fire    = out_ch.valid && out_ch.ready;

  always_comb begin
    credit_nxt = credit_r;
    if (fetch_in && !out_fire) begin
      credit_nxt = credit_r + 1'b1;
    end else if (!fetch_in && out_fire) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  // Stage 0: range check and the two products of coordinate and source size.
  // Stages 1..7: one quotient bit per axis each, restoring division by the
  // destination size. Since the coordinate is below the destination size,
  // the quotient is below the source size and fits in seven bits.
  logic               valid_r [0:DIV_STAGES];
  nnis_pkg::tag_t     tag_r   [0:DIV_STAGES];
  nnis_pkg::div_t     div_r   [0:DIV_STAGES];

  logic [nnis_pkg::NUM_W-1:0] px_in, py_in;
  logic                       err_in;

  assign px_in  = nnis_pkg::NUM_W'(in_ch.dest_x) * nnis_pkg::NUM_W'(src_width_r);
  assign py_in  = nnis_pkg::NUM_W'(in_ch.dest_y) * nnis_pkg::NUM_W'(src_height_r);
  assign err_in = (nnis_pkg::DST_DIM_W'(in_ch.dest_x) >= dst_width_r) ||
                  (nnis_pkg::DST_DIM_W'(in_ch.dest_y) >= dst_height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0].fetch <= (in_ch.opcode == nnis_pkg::OP_FETCH);
    tag_r[0].err   <= err_in;
    tag_r[0].laddr <= in_ch.load_address;
    tag_r[0].lval  <= in_ch.load_value;
    div_r[0].px    <= px_in;
    div_r[0].py    <= py_in;
    div_r[0].rx    <= nnis_pkg::REM_W'(px_in[nnis_pkg::NUM_W-1:nnis_pkg::QUOT_W]);
    div_r[0].ry    <= nnis_pkg::REM_W'(py_in[nnis_pkg::NUM_W-1:nnis_pkg::QUOT_W]);
    div_r[0].qx    <= '0;
    div_r[0].qy    <= '0;
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [nnis_pkg::REM_W:0] tx, ty;
    logic [nnis_pkg::REM_W:0] dwx, dhy;
    logic                     gex, gey;

    assign dwx = (nnis_pkg::REM_W+1)'(dst_width_r);
    assign dhy = (nnis_pkg::REM_W+1)'(dst_height_r);
    assign tx  = {div_r[k-1].rx, div_r[k-1].px[DIV_STAGES-k]};
    assign ty  = {div_r[k-1].ry, div_r[k-1].py[DIV_STAGES-k]};
    assign gex = (tx >= dwx);
    assign gey = (ty >= dhy);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= valid_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[k]    <= tag_r[k-1];
      div_r[k].px <= div_r[k-1].px;
      div_r[k].py <= div_r[k-1].py;
      div_r[k].rx <= gex ? nnis_pkg::REM_W'(tx - dwx) : tx[nnis_pkg::REM_W-1:0];
      div_r[k].ry <= gey ? nnis_pkg::REM_W'(ty - dhy) : ty[nnis_pkg::REM_W-1:0];
      div_r[k].qx <= {div_r[k-1].qx[nnis_pkg::QUOT_W-2:0], gex};
      div_r[k].qy <= {div_r[k-1].qy[nnis_pkg::QUOT_W-2:0], gey};
    end
  end

  // Address stage: row * src_width + column.
  logic                               addr_valid_r;
  nnis_pkg::tag_t                     addr_tag_r;
  logic [nnis_pkg::SRC_ADDR_W-1:0]    src_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_valid_r <= 1'b0;
    end else begin
      addr_valid_r <= valid_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    addr_tag_r <= tag_r[DIV_STAGES];
    src_addr_r <= nnis_pkg::SRC_ADDR_W'(div_r[DIV_STAGES].qy) *
                    nnis_pkg::SRC_ADDR_W'(src_width_r) +
                  nnis_pkg::SRC_ADDR_W'(div_r[DIV_STAGES].qx);
  end

  // Pixel store. Loads and fetches reach this stage in acceptance order and
  // each is handled in its own cycle, so a fetch always sees every earlier
  // load without forwarding.
  logic [nnis_pkg::PIXEL_W-1:0] pixel_mem [0:nnis_pkg::MAX_SOURCE_PIXELS-1];
  logic [nnis_pkg::PIXEL_W-1:0] rdata_r;
  logic                         mem_valid_r;
  logic                         mem_fetch_r;
  logic                         mem_err_r;
  logic                         mem_zero_r;
  logic                         load_ok;
  logic                         fetch_oob;

  assign load_ok   = addr_valid_r && !addr_tag_r.fetch &&
                     (nnis_pkg::SRC_ADDR_W'(addr_tag_r.laddr) < MAX_ADDR);
  assign fetch_oob = (src_addr_r >= MAX_ADDR);

  always_ff @(posedge clk) begin
    if (load_ok) begin
      pixel_mem[addr_tag_r.laddr[nnis_pkg::ADDR_W-1:0]] <= addr_tag_r.lval;
    end
    rdata_r <= pixel_mem[src_addr_r[nnis_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_valid_r <= 1'b0;
    end else begin
      mem_valid_r <= addr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    mem_fetch_r <= addr_tag_r.fetch;
    mem_err_r   <= addr_tag_r.err;
    mem_zero_r  <= addr_tag_r.err || fetch_oob;
  end

  // Result queue.
  nnis_pkg::res_t                   fifo_mem [0:nnis_pkg::FIFO_DEPTH-1];
  nnis_pkg::res_t                   push_data;
  logic [nnis_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [nnis_pkg::FIFO_CNT_W-1:0]  fifo_cnt_r, fifo_cnt_nxt;
  logic                             push;

  assign push                  = mem_valid_r && mem_fetch_r;
  assign push_data.pixel_out   = mem_zero_r ? '0 : rdata_r;
  assign push_data.coord_error = mem_err_r;

  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r;
    if (push && !out_fire) begin
      fifo_cnt_nxt = fifo_cnt_r + 1'b1;
    end else if (!push && out_fire) begin
      fifo_cnt_nxt = fifo_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_data;
    end
  end

  assign out_ch.valid       = (fifo_cnt_r != '0);
  assign out_ch.pixel_out   = fifo_mem[rd_ptr_r].pixel_out;
  assign out_ch.coord_error = fifo_mem[rd_ptr_r].coord_error;

  // The credit count always covers what sits in the queue.
  a_credit_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= credit_r)
    else $error("queue holds more results than issued credits");

  // A result is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_cnt_r < nnis_pkg::FIFO_CNT_W'(nnis_pkg::FIFO_DEPTH)) || out_fire)
    else $error("result queue overflow");

  // A flagged coordinate always comes with a zero pixel.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.coord_error) |-> (out_ch.pixel_out == '0))
    else $error("coordinate error with nonzero pixel");

  // A fetch accepted with an empty pipeline reaches the queue on schedule.
  a_fetch_latency: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_in |-> ##(DIV_STAGES + 3) push)
    else $error("fetch did not reach the result queue");

endmodule

### tb/nnis_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts every fetch result
// and compares it with what the scaler returns.
module nnis_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  nnis_in_if                              in_mon,
  nnis_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending_count
);

  logic [nnis_pkg::SRC_DIM_W-1:0] src_w;
  logic [nnis_pkg::SRC_DIM_W-1:0] src_h;
  logic [nnis_pkg::DST_DIM_W-1:0] dst_w;
  logic [nnis_pkg::DST_DIM_W-1:0] dst_h;
  logic [nnis_pkg::PIXEL_W-1:0]   src_store [nnis_pkg::MAX_SOURCE_PIXELS];
  nnis_pkg::res_t                 scaled_px_q[$];
  nnis_pkg::res_t                 want;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    fail_count++;
  endtask

  // Nearest source pixel for one destination coordinate.
  function automatic nnis_pkg::res_t scaled_pixel(
      input logic [nnis_pkg::COORD_W-1:0] dx,
      input logic [nnis_pkg::COORD_W-1:0] dy);
    int unsigned    col;
    int unsigned    row;
    int unsigned    addr;
    nnis_pkg::res_t r;
    r.coord_error = 1'b0;
    r.pixel_out   = '0;
    if (dx >= dst_w || dy >= dst_h) begin
      r.coord_error = 1'b1;
      return r;
    end
    col  = (32'(dx) * 32'(src_w)) / 32'(dst_w);
    row  = (32'(dy) * 32'(src_h)) / 32'(dst_h);
    addr = row * 32'(src_w) + col;
    if (addr < nnis_pkg::MAX_SOURCE_PIXELS) begin
      r.pixel_out = src_store[addr];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      src_w = nnis_pkg::SRC_WIDTH_RST;
      src_h = nnis_pkg::SRC_HEIGHT_RST;
      dst_w = nnis_pkg::DST_WIDTH_RST;
      dst_h = nnis_pkg::DST_HEIGHT_RST;
      scaled_px_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (scaled_px_q.size() == 0) begin
          report_mismatch($sformatf("result %08h/%0b with no fetch waiting",
                                    out_mon.pixel_out, out_mon.coord_error));
        end else begin
          want = scaled_px_q.pop_front();
          if (out_mon.pixel_out !== want.pixel_out) begin
            report_mismatch($sformatf("pixel_out %08h, expected %08h",
                                      out_mon.pixel_out, want.pixel_out));
          end
          if (out_mon.coord_error !== want.coord_error) begin
            report_mismatch($sformatf("coord_error %b, expected %b",
                                      out_mon.coord_error, want.coord_error));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.opcode == nnis_pkg::OP_LOAD) begin
          src_store[in_mon.load_address] = in_mon.load_value;
        end else begin
          scaled_px_q.push_back(scaled_pixel(in_mon.dest_x, in_mon.dest_y));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          nnis_pkg::CFG_SRC_WIDTH:  src_w = cfg_wdata[nnis_pkg::SRC_DIM_W-1:0];
          nnis_pkg::CFG_SRC_HEIGHT: src_h = cfg_wdata[nnis_pkg::SRC_DIM_W-1:0];
          nnis_pkg::CFG_DST_WIDTH:  dst_w = cfg_wdata[nnis_pkg::DST_DIM_W-1:0];
          nnis_pkg::CFG_DST_HEIGHT: dst_h = cfg_wdata[nnis_pkg::DST_DIM_W-1:0];
          default: ;
        endcase
      end
    end
    pending_count <= scaled_px_q.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the nearest-neighbor scaler. The checker instance
// beside the block does all prediction and comparison; this module only makes
// traffic, paces both channels and reports the outcome.
module tb_top;

  logic                            clk   = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we;
  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                              fail_count;
  int                              pending_count;

  // Stimulus-side copy of the sizes, used only to aim loads and fetches and to
  // make sure no fetch ever reads a store entry that has not been loaded.
  int unsigned sw;
  int unsigned sh;
  int unsigned dw;
  int unsigned dh;
  bit          load_seen [nnis_pkg::MAX_SOURCE_PIXELS];

  // When calm is set neither side idles. A request on hold_req makes the
  // receiver refuse results for a long stretch while items keep coming.
  bit calm;
  bit hold_req;

  int unsigned phase_sizes [8][4] = '{
    '{64, 64, 256, 256},
    '{1, 1, 1, 1},
    '{0, 0, 10, 10},
    '{127, 127, 5, 5},
    '{7, 5, 0, 0},
    '{64, 64, 511, 511},
    '{3, 64, 256, 2},
    '{16, 8, 33, 17}
  };

  nnis_in_if  in_ch ();
  nnis_out_if out_ch ();

  nearest_neighbor_image_scaler_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nnis_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs or loses a result.
  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side. Ready drops about 17 percent of the time, never while
  // calm is set. A hold request parks ready low for longer than the 16-entry
  // result queue can absorb.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  // Offers one item and returns at the edge where it is taken. Random gaps
  // come before the item, and valid is written only once per edge.
  task automatic send_item(input logic                             op,
                           input logic [nnis_pkg::LOAD_ADDR_W-1:0] la,
                           input logic [nnis_pkg::PIXEL_W-1:0]     lv,
                           input logic [nnis_pkg::COORD_W-1:0]     dx,
                           input logic [nnis_pkg::COORD_W-1:0]     dy);
    while (!calm && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.load_address <= la;
    in_ch.load_value   <= lv;
    in_ch.dest_x       <= dx;
    in_ch.dest_y       <= dy;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // The coordinate fields of a load are ignored by the block, so they carry
  // noise; the same goes for the load fields of a fetch.
  task automatic load_pixel(input logic [nnis_pkg::LOAD_ADDR_W-1:0] a,
                            input logic [nnis_pkg::PIXEL_W-1:0]     v);
    send_item(nnis_pkg::OP_LOAD, a, v,
              nnis_pkg::COORD_W'($urandom), nnis_pkg::COORD_W'($urandom));
    load_seen[a] = 1'b1;
  endtask

  // A fetch that lands on a never-loaded entry gets a load of that entry
  // first, so the store is always defined where it is read. Out-of-range
  // coordinates and addresses past the store read nothing.
  task automatic fetch_pixel(input logic [nnis_pkg::COORD_W-1:0] dx,
                             input logic [nnis_pkg::COORD_W-1:0] dy);
    int unsigned a;
    if (dx < dw && dy < dh) begin
      a = ((32'(dy) * sh) / dh) * sw + (32'(dx) * sw) / dw;
      if (a < nnis_pkg::MAX_SOURCE_PIXELS && !load_seen[a]) begin
        load_pixel(nnis_pkg::LOAD_ADDR_W'(a), $urandom());
      end
    end
    send_item(nnis_pkg::OP_FETCH, nnis_pkg::LOAD_ADDR_W'($urandom), $urandom(), dx, dy);
  endtask

  // Lets the block run dry: no result outstanding, then enough cycles for a
  // trailing load to leave the pipeline.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (20) @(posedge clk);
  endtask

  // Sizes change only on an idle block.
  task automatic set_sizes(input int unsigned s_w, input int unsigned s_h,
                           input int unsigned d_w, input int unsigned d_h);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= nnis_pkg::CFG_SRC_WIDTH;
    cfg_wdata <= nnis_pkg::CFG_DATA_W'(s_w);
    @(posedge clk);
    cfg_index <= nnis_pkg::CFG_SRC_HEIGHT;
    cfg_wdata <= nnis_pkg::CFG_DATA_W'(s_h);
    @(posedge clk);
    cfg_index <= nnis_pkg::CFG_DST_WIDTH;
    cfg_wdata <= nnis_pkg::CFG_DATA_W'(d_w);
    @(posedge clk);
    cfg_index <= nnis_pkg::CFG_DST_HEIGHT;
    cfg_wdata <= nnis_pkg::CFG_DATA_W'(d_h);
    @(posedge clk);
    cfg_we <= 1'b0;
    sw = s_w;
    sh = s_h;
    dw = d_w;
    dh = d_h;
  endtask

  // Random traffic under the current sizes: a quarter loads, most of the
  // rest fetches inside the destination image, and the remainder fetches
  // anywhere in the coordinate range to hit the error path.
  task automatic run_random(input int n);
    int unsigned r;
    int unsigned area;
    int unsigned x_max;
    int unsigned y_max;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 25) begin
        area = sw * sh;
        if ($urandom_range(1) && area > 0 && area <= nnis_pkg::MAX_SOURCE_PIXELS) begin
          load_pixel(nnis_pkg::LOAD_ADDR_W'($urandom_range(area - 1)), $urandom());
        end else begin
          load_pixel(nnis_pkg::LOAD_ADDR_W'($urandom_range(nnis_pkg::MAX_SOURCE_PIXELS - 1)),
                     $urandom());
        end
      end else if (r < 85 && dw > 0 && dh > 0) begin
        x_max = (dw > 256) ? 255 : dw - 1;
        y_max = (dh > 256) ? 255 : dh - 1;
        fetch_pixel(nnis_pkg::COORD_W'($urandom_range(x_max)),
                    nnis_pkg::COORD_W'($urandom_range(y_max)));
      end else begin
        fetch_pixel(nnis_pkg::COORD_W'($urandom_range(255)),
                    nnis_pkg::COORD_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= nnis_pkg::OP_LOAD;
    in_ch.load_address <= '0;
    in_ch.load_value   <= '0;
    in_ch.dest_x       <= '0;
    in_ch.dest_y       <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= nnis_pkg::CFG_SRC_WIDTH;
    cfg_wdata          <= '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    sw = nnis_pkg::SRC_WIDTH_RST;
    sh = nnis_pkg::SRC_HEIGHT_RST;
    dw = nnis_pkg::DST_WIDTH_RST;
    dh = nnis_pkg::DST_HEIGHT_RST;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first on the reset sizes: extreme addresses and
    // colors, corners of the destination, and coordinates just outside it.
    load_pixel(12'h000, 32'hFFFF_FFFF);
    load_pixel(12'hFFF, 32'h0000_0000);
    load_pixel(12'hAAA, 32'h5555_5555);
    load_pixel(12'h555, 32'hAAAA_AAAA);
    fetch_pixel(8'd0, 8'd0);
    fetch_pixel(8'd39, 8'd39);
    fetch_pixel(8'd40, 8'd0);
    fetch_pixel(8'd0, 8'd40);
    fetch_pixel(8'd255, 8'd255);
    // A fetch right behind a load of the entry it reads.
    load_pixel(12'h000, 32'h1234_5678);
    fetch_pixel(8'd0, 8'd0);

    // Largest legal image: the far corner maps to the last store entry.
    set_sizes(64, 64, 256, 256);
    fetch_pixel(8'd255, 8'd255);
    fetch_pixel(8'd0, 8'd255);
    fetch_pixel(8'd255, 8'd0);

    // Oversized source: some scaled addresses fall past the end of the store
    // and must read as zero without an error.
    set_sizes(127, 127, 5, 5);
    fetch_pixel(8'd4, 8'd4);
    fetch_pixel(8'd1, 8'd0);
    fetch_pixel(8'd0, 8'd0);

    // A zero source size folds each axis onto index zero.
    set_sizes(0, 0, 10, 10);
    fetch_pixel(8'd9, 8'd9);
    fetch_pixel(8'd10, 8'd3);

    // A zero destination size makes every fetch a coordinate error.
    set_sizes(7, 5, 0, 0);
    fetch_pixel(8'd0, 8'd0);

    // Random part: fixed size sets including the extremes, then a few drawn
    // at random. The first and the seventh carry a long receiver hold-off;
    // the sixth runs without any idling on either side.
    for (int p = 0; p < 8; p++) begin
      set_sizes(phase_sizes[p][0], phase_sizes[p][1], phase_sizes[p][2], phase_sizes[p][3]);
      calm = (p == 5);
      if (p == 0 || p == 6) begin
        hold_req = 1'b1;
      end
      run_random(75);
    end
    calm = 1'b0;
    for (int p = 0; p < 3; p++) begin
      set_sizes($urandom_range(1, 64), $urandom_range(1, 64),
                $urandom_range(1, 256), $urandom_range(1, 256));
      run_random(75);
    end

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
